// ===== rtl/core/lca_pkg.sv =====
// Shared types, constants and helpers for the tree LCA binary-lifting core.
`default_nettype none
package lca_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;
  localparam int MAX_EDGES   = 2048;

  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int EREF_W  = $clog2(MAX_EDGES + 1);
  localparam int EIDX_W  = $clog2(MAX_EDGES);
  localparam int DEPTH_W = $clog2(MAX_NODES);
  localparam int LV_W    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int STK_AW  = $clog2(MAX_NODES);
  localparam int SLOTS   = 2 ** NODE_W;
  localparam int ANC_AW  = $clog2(LIFT_LEVELS * SLOTS);

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_BUILD = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOTBLT  = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } lca_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [1:0]        status;
  } lca_out_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              bad;
  } lca_job_t;

  function automatic logic in_rng(input logic [NODE_W-1:0] v,
                                  input logic [NODE_W-1:0] cnt);
    in_rng = (v != '0) && (v <= cnt);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lca_front.sv =====
// Front stage: accept input beats, range-check the nodes, hand jobs to the queue.
`default_nettype none
module lca_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  lca_pkg::lca_in_t         in_data,
  input  wire [lca_pkg::NODE_W-1:0] node_count,
  input  wire                      hold,
  output logic                     job_valid,
  input  wire                      job_ready,
  output lca_pkg::lca_job_t        job_data
);
  import lca_pkg::*;

  logic     f_valid_r, f_valid_nxt;
  lca_job_t f_job_r;

  assign in_ready  = !hold && (!f_valid_r || job_ready);
  assign job_valid = f_valid_r;
  assign job_data  = f_job_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (job_ready) f_valid_nxt = 1'b0;
    if (in_valid && in_ready) f_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_job_r.func   <= in_data.func;
      f_job_r.node_a <= in_data.node_a;
      f_job_r.node_b <= in_data.node_b;
      f_job_r.bad    <= !(in_rng(in_data.node_a, node_count) &&
                          in_rng(in_data.node_b, node_count));
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/lca_queue.sv =====
// Two-entry job queue between the front and back stages.
`default_nettype none
module lca_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_valid,
  output logic              wr_ready,
  input  lca_pkg::lca_job_t wr_data,
  output logic              rd_valid,
  input  wire               rd_ready,
  output lca_pkg::lca_job_t rd_data
);
  import lca_pkg::*;

  lca_job_t   slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== rtl/core/lca_back.sv =====
// Back stage: edge lists, depth-first build, ancestor table and query sequencer.
`default_nettype none
module lca_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       job_valid,
  output logic                      job_ready,
  input  lca_pkg::lca_job_t         job_data,
  input  wire [lca_pkg::NODE_W-1:0] node_count,
  input  wire                       cfg_wr,
  output logic                      init_busy,
  output logic                      out_valid,
  input  wire                       out_ready,
  output lca_pkg::lca_out_t         out_data
);
  import lca_pkg::*;

  localparam logic [4:0] S_SWEEP  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ADD    = 5'd2;
  localparam logic [4:0] S_LINK   = 5'd3;
  localparam logic [4:0] S_BSWEEP = 5'd4;
  localparam logic [4:0] S_BROOT  = 5'd5;
  localparam logic [4:0] S_BHEAD  = 5'd6;
  localparam logic [4:0] S_WSTEP  = 5'd7;
  localparam logic [4:0] S_WEDGE  = 5'd8;
  localparam logic [4:0] S_WCHECK = 5'd9;
  localparam logic [4:0] S_WPOP   = 5'd10;
  localparam logic [4:0] S_FRD1   = 5'd11;
  localparam logic [4:0] S_FRD2   = 5'd12;
  localparam logic [4:0] S_FWR    = 5'd13;
  localparam logic [4:0] S_QDEP   = 5'd14;
  localparam logic [4:0] S_QL1    = 5'd15;
  localparam logic [4:0] S_QL2    = 5'd16;
  localparam logic [4:0] S_QL3    = 5'd17;
  localparam logic [4:0] S_QP1    = 5'd18;
  localparam logic [4:0] S_QP2    = 5'd19;
  localparam logic [4:0] S_QFIN   = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  localparam int STK_W = NODE_W + EREF_W + DEPTH_W;
  localparam logic [LV_W-1:0] LV_TOP = LV_W'(LIFT_LEVELS - 1);

  // memories
  logic [2*EREF_W-1:0] node_mem [0:MAX_NODES];
  logic [NODE_W-1:0]   tgt_mem  [0:MAX_EDGES-1];
  logic [EREF_W-1:0]   nxt_mem  [0:MAX_EDGES-1];
  logic                rch_mem  [0:MAX_NODES];
  logic [DEPTH_W-1:0]  dep_mem  [0:MAX_NODES];
  logic [NODE_W-1:0]   anc_mem  [0:LIFT_LEVELS*SLOTS-1];
  logic [STK_W-1:0]    stk_mem  [0:MAX_NODES-1];

  logic                node_we;
  logic [NODE_W-1:0]   node_wa, node_ra;
  logic [2*EREF_W-1:0] node_wd, node_rd_r;
  logic                tgt_we, nxt_we;
  logic [EIDX_W-1:0]   tgt_wa, nxt_wa, edge_ra;
  logic [NODE_W-1:0]   tgt_wd, tgt_rd_r;
  logic [EREF_W-1:0]   nxt_wd, nxt_rd_r;
  logic                rch_we, rch_wd, rch_rd_r;
  logic [NODE_W-1:0]   rch_wa, rch_ra;
  logic                dep_we;
  logic [NODE_W-1:0]   dep_wa, dep_ra0, dep_ra1;
  logic [DEPTH_W-1:0]  dep_wd, dep_rd0_r, dep_rd1_r;
  logic                anc_we;
  logic [ANC_AW-1:0]   anc_wa, anc_ra0, anc_ra1;
  logic [NODE_W-1:0]   anc_wd, anc_rd0_r, anc_rd1_r;
  logic                stk_we;
  logic [STK_AW-1:0]   stk_wa, stk_ra;
  logic [STK_W-1:0]    stk_wd, stk_rd_r;

  // control
  logic [4:0]          state_r, state_nxt;
  logic                init_r, init_nxt;
  logic [NODE_W-1:0]   cnt_r, cnt_nxt;
  logic [LV_W-1:0]     lv_r, lv_nxt;
  logic [EREF_W-1:0]   fill_r, fill_nxt;
  logic                built_r, built_nxt;
  lca_job_t            job_r, job_nxt;
  logic [NODE_W-1:0]   qa_r, qa_nxt, qb_r, qb_nxt, v_r, v_nxt;
  logic [DEPTH_W-1:0]  qdb_r, qdb_nxt;
  logic [NODE_W-1:0]   cu_r, cu_nxt;
  logic [EREF_W-1:0]   cc_r, cc_nxt;
  logic [DEPTH_W-1:0]  cd_r, cd_nxt;
  logic [NODE_W-1:0]   top_r, top_nxt;
  lca_out_t            res_r, res_nxt;
  logic                ov_r, ov_nxt;
  lca_out_t            od_r;
  logic                load_out;

  function automatic logic [ANC_AW-1:0] anc_addr(input logic [LV_W-1:0] lv,
                                                 input logic [NODE_W-1:0] n);
    anc_addr = ANC_AW'(lv) * ANC_AW'(SLOTS) + ANC_AW'(n);
  endfunction

  assign init_busy = init_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign load_out  = (state_r == S_DONE) && (!ov_r || out_ready);

  always_comb begin
    logic [NODE_W-1:0] qa_t;
    state_nxt = state_r;
    init_nxt  = init_r;
    cnt_nxt   = cnt_r;
    lv_nxt    = lv_r;
    fill_nxt  = fill_r;
    built_nxt = built_r;
    job_nxt   = job_r;
    qa_nxt    = qa_r;
    qb_nxt    = qb_r;
    qdb_nxt   = qdb_r;
    v_nxt     = v_r;
    cu_nxt    = cu_r;
    cc_nxt    = cc_r;
    cd_nxt    = cd_r;
    top_nxt   = top_r;
    res_nxt   = res_r;
    qa_t      = qa_r;
    job_ready = 1'b0;
    node_we = 1'b0; node_wa = '0; node_wd = '0; node_ra = '0;
    tgt_we  = 1'b0; tgt_wa  = '0; tgt_wd  = '0;
    nxt_we  = 1'b0; nxt_wa  = '0; nxt_wd  = '0; edge_ra = '0;
    rch_we  = 1'b0; rch_wa  = '0; rch_wd  = 1'b0; rch_ra = '0;
    dep_we  = 1'b0; dep_wa  = '0; dep_wd  = '0; dep_ra0 = '0; dep_ra1 = '0;
    anc_we  = 1'b0; anc_wa  = '0; anc_wd  = '0; anc_ra0 = '0; anc_ra1 = '0;
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra = '0;

    case (state_r)
      S_SWEEP: begin
        node_we = 1'b1;
        node_wa = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NODE_W'(MAX_NODES)) begin
          cnt_nxt = '0;
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            res_nxt   = '{ancestor: '0, status: ST_OK};
            state_nxt = S_DONE;
          end
        end
      end
      S_IDLE: begin
        if (job_valid) begin
          job_ready = 1'b1;
          job_nxt   = job_data;
          res_nxt   = '{ancestor: '0, status: ST_OK};
          cnt_nxt   = '0;
          case (job_data.func)
            FUNC_CLEAR: begin
              fill_nxt  = '0;
              built_nxt = 1'b0;
              state_nxt = S_SWEEP;
            end
            FUNC_ADD: begin
              if (job_data.bad) begin
                res_nxt.status = ST_BAD;
                state_nxt      = S_DONE;
              end else if (fill_r == EREF_W'(MAX_EDGES)) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                node_ra   = job_data.node_a;
                state_nxt = S_ADD;
              end
            end
            FUNC_BUILD: state_nxt = S_BSWEEP;
            default: begin
              if (job_data.bad) begin
                res_nxt.status = ST_BAD;
                state_nxt      = S_DONE;
              end else if (!built_r) begin
                res_nxt.status = ST_NOTBLT;
                state_nxt      = S_DONE;
              end else begin
                dep_ra0   = job_data.node_a;
                dep_ra1   = job_data.node_b;
                state_nxt = S_QDEP;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        tgt_we    = 1'b1;
        tgt_wa    = fill_r[EIDX_W-1:0];
        tgt_wd    = job_r.node_b;
        nxt_we    = 1'b1;
        nxt_wa    = fill_r[EIDX_W-1:0];
        nxt_wd    = '0;
        node_we   = 1'b1;
        node_wa   = job_r.node_a;
        fill_nxt  = fill_r + 1'b1;
        built_nxt = 1'b0;
        cc_nxt    = node_rd_r[EREF_W-1:0];
        if (node_rd_r[EREF_W-1:0] == '0) begin
          node_wd   = {fill_nxt, fill_nxt};
          state_nxt = S_DONE;
        end else begin
          node_wd   = {node_rd_r[2*EREF_W-1:EREF_W], fill_nxt};
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        nxt_we    = 1'b1;
        nxt_wa    = EIDX_W'(cc_r - 1'b1);
        nxt_wd    = fill_r;
        state_nxt = S_DONE;
      end
      S_BSWEEP: begin
        anc_we  = 1'b1;
        anc_wa  = anc_addr('0, cnt_r);
        anc_wd  = NODE_W'(1);
        dep_we  = 1'b1;
        dep_wa  = cnt_r;
        dep_wd  = DEPTH_W'(1);
        rch_we  = 1'b1;
        rch_wa  = cnt_r;
        rch_wd  = 1'b0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NODE_W'(MAX_NODES)) state_nxt = S_BROOT;
      end
      S_BROOT: begin
        dep_we    = 1'b1;
        dep_wa    = NODE_W'(1);
        dep_wd    = '0;
        rch_we    = 1'b1;
        rch_wa    = NODE_W'(1);
        rch_wd    = 1'b1;
        node_ra   = NODE_W'(1);
        state_nxt = S_BHEAD;
      end
      S_BHEAD: begin
        cu_nxt    = NODE_W'(1);
        cc_nxt    = node_rd_r[2*EREF_W-1:EREF_W];
        cd_nxt    = '0;
        top_nxt   = NODE_W'(1);
        state_nxt = S_WSTEP;
      end
      S_WSTEP: begin
        if (cc_r == '0 || cc_r > EREF_W'(MAX_EDGES)) begin
          top_nxt = top_r - 1'b1;
          if (top_r == NODE_W'(1)) begin
            lv_nxt  = LV_W'(1);
            cnt_nxt = NODE_W'(1);
            if (LIFT_LEVELS > 1) begin
              state_nxt = S_FRD1;
            end else begin
              built_nxt = 1'b1;
              state_nxt = S_DONE;
            end
          end else begin
            stk_ra    = STK_AW'(top_r - NODE_W'(2));
            state_nxt = S_WPOP;
          end
        end else begin
          edge_ra   = EIDX_W'(cc_r - 1'b1);
          state_nxt = S_WEDGE;
        end
      end
      S_WPOP: begin
        {cu_nxt, cc_nxt, cd_nxt} = stk_rd_r;
        state_nxt = S_WSTEP;
      end
      S_WEDGE: begin
        cc_nxt    = nxt_rd_r;
        v_nxt     = tgt_rd_r;
        rch_ra    = in_rng(tgt_rd_r, node_count) ? tgt_rd_r : '0;
        node_ra   = rch_ra;
        state_nxt = S_WCHECK;
      end
      S_WCHECK: begin
        state_nxt = S_WSTEP;
        if (in_rng(v_r, node_count) && !rch_rd_r) begin
          rch_we = 1'b1;
          rch_wa = v_r;
          rch_wd = 1'b1;
          anc_we = 1'b1;
          anc_wa = anc_addr('0, v_r);
          anc_wd = cu_r;
          dep_we = 1'b1;
          dep_wa = v_r;
          dep_wd = cd_r + 1'b1;
          if (top_r < NODE_W'(MAX_NODES)) begin
            stk_we  = 1'b1;
            stk_wa  = STK_AW'(top_r - 1'b1);
            stk_wd  = {cu_r, cc_r, cd_r};
            cu_nxt  = v_r;
            cc_nxt  = node_rd_r[2*EREF_W-1:EREF_W];
            cd_nxt  = cd_r + 1'b1;
            top_nxt = top_r + 1'b1;
          end
        end
      end
      S_FRD1: begin
        anc_ra0   = anc_addr(lv_r - 1'b1, cnt_r);
        state_nxt = S_FRD2;
      end
      S_FRD2: begin
        anc_ra0   = anc_addr(lv_r - 1'b1, anc_rd0_r);
        state_nxt = S_FWR;
      end
      S_FWR: begin
        anc_we    = 1'b1;
        anc_wa    = anc_addr(lv_r, cnt_r);
        anc_wd    = anc_rd0_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_FRD1;
        if (cnt_r == node_count) begin
          cnt_nxt = NODE_W'(1);
          if (lv_r == LV_TOP) begin
            built_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            lv_nxt = lv_r + 1'b1;
          end
        end
      end
      S_QDEP: begin
        if (dep_rd0_r < dep_rd1_r) begin
          qa_nxt  = job_r.node_b;
          qb_nxt  = job_r.node_a;
          qdb_nxt = dep_rd0_r;
        end else begin
          qa_nxt  = job_r.node_a;
          qb_nxt  = job_r.node_b;
          qdb_nxt = dep_rd1_r;
        end
        lv_nxt    = LV_TOP;
        state_nxt = S_QL1;
      end
      S_QL1: begin
        anc_ra0   = anc_addr(lv_r, qa_r);
        state_nxt = S_QL2;
      end
      S_QL2: begin
        v_nxt     = anc_rd0_r;
        dep_ra0   = anc_rd0_r;
        state_nxt = S_QL3;
      end
      S_QL3: begin
        if (dep_rd0_r >= qdb_r) qa_t = v_r;
        qa_nxt = qa_t;
        if (lv_r == '0) begin
          lv_nxt = LV_TOP;
          if (qa_t == qb_r) begin
            res_nxt.ancestor = qa_t;
            state_nxt        = S_DONE;
          end else begin
            state_nxt = S_QP1;
          end
        end else begin
          lv_nxt    = lv_r - 1'b1;
          state_nxt = S_QL1;
        end
      end
      S_QP1: begin
        anc_ra0   = anc_addr(lv_r, qa_r);
        anc_ra1   = anc_addr(lv_r, qb_r);
        state_nxt = S_QP2;
      end
      S_QP2: begin
        if (anc_rd0_r != anc_rd1_r) begin
          qa_t   = anc_rd0_r;
          qb_nxt = anc_rd1_r;
        end
        qa_nxt = qa_t;
        if (lv_r == '0) begin
          anc_ra0   = anc_addr('0, qa_t);
          state_nxt = S_QFIN;
        end else begin
          lv_nxt    = lv_r - 1'b1;
          state_nxt = S_QP1;
        end
      end
      S_QFIN: begin
        res_nxt.ancestor = anc_rd0_r;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_wr) built_nxt = 1'b0;
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (load_out) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      init_r  <= 1'b1;
      cnt_r   <= '0;
      fill_r  <= '0;
      built_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      cnt_r   <= cnt_nxt;
      fill_r  <= fill_nxt;
      built_r <= built_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r  <= lv_nxt;
    job_r <= job_nxt;
    qa_r  <= qa_nxt;
    qb_r  <= qb_nxt;
    qdb_r <= qdb_nxt;
    v_r   <= v_nxt;
    cu_r  <= cu_nxt;
    cc_r  <= cc_nxt;
    cd_r  <= cd_nxt;
    top_r <= top_nxt;
    res_r <= res_nxt;
    if (load_out) od_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd_r <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    tgt_rd_r <= tgt_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_r <= nxt_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (rch_we) rch_mem[rch_wa] <= rch_wd;
    rch_rd_r <= rch_mem[rch_ra];
  end

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_wa] <= dep_wd;
    dep_rd0_r <= dep_mem[dep_ra0];
    dep_rd1_r <= dep_mem[dep_ra1];
  end

  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_wa] <= anc_wd;
    anc_rd0_r <= anc_mem[anc_ra0];
    anc_rd1_r <= anc_mem[anc_ra1];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end
endmodule
`default_nettype wire

// ===== rtl/core/tree_lca_binary_lifting_core.sv =====
// Top level: config register, front stage, job queue and back stage.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one beat per item: clear,
//   add neighbour, build or query. Every item gives exactly one result beat
//   on the output channel (out_valid/out_ready/out_data) with a status.
//   The APB port holds node_count at any address; a write clamps it to
//   1..1024 and marks the ancestor tables stale.
// Steps per item, as run by the back-stage sequencer:
//   range or status errors: straight to the result, with no table access.
//   add neighbour: list head/tail read, then link write if the list was not empty.
//   clear: one list-head entry swept per cycle.
//   build: table sweep, then a depth-first walk over the edges and popped nodes,
//   then one pass over the nodes for each of the 9 upper lifting levels.
//   query: equalize depth level by level, then lift level by level.
// Items are handled one at a time; the front stage and a two-beat queue take
// new beats while the back stage works.
// After reset the block sweeps the 1025 list heads with in_ready low.
// A stalled receiver holds the result in the output register and the back
// stage waits until it is taken.
`default_nettype none
module tree_lca_binary_lifting_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  lca_pkg::lca_in_t          in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output lca_pkg::lca_out_t         out_data,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [1:0]                 paddr,
  input  wire [31:0]                pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import lca_pkg::*;

  logic [NODE_W-1:0] ncnt_r, ncnt_nxt;
  logic              cfg_wr;
  logic              init_busy;
  logic              fj_valid, fj_ready, qj_valid, qj_ready;
  lca_job_t          fj_data, qj_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'd0 || 1'b1);
  assign prdata = 32'(ncnt_r);

  always_comb begin
    ncnt_nxt = ncnt_r;
    if (cfg_wr) begin
      if (pwdata[NODE_W-1:0] == '0) ncnt_nxt = NODE_W'(1);
      else if (pwdata[NODE_W-1:0] > NODE_W'(MAX_NODES)) ncnt_nxt = NODE_W'(MAX_NODES);
      else ncnt_nxt = pwdata[NODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncnt_r <= NODE_W'(1);
    end else begin
      ncnt_r <= ncnt_nxt;
    end
  end

  lca_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .node_count (ncnt_r),
    .hold       (init_busy),
    .job_valid  (fj_valid),
    .job_ready  (fj_ready),
    .job_data   (fj_data)
  );

  lca_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj_data),
    .rd_valid (qj_valid),
    .rd_ready (qj_ready),
    .rd_data  (qj_data)
  );

  lca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (qj_valid),
    .job_ready  (qj_ready),
    .job_data   (qj_data),
    .node_count (ncnt_r),
    .cfg_wr     (cfg_wr),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );
endmodule
`default_nettype wire
